// ----- sv/lmd_pkg.sv -----
// Shared types, constants and lookup functions of the lagged moment difference block.
package lmd_pkg;

    localparam int NMOM      = 15;
    localparam int MAX_LAG   = 25;
    localparam int SUM_DEPTH = 2 * NMOM;
    localparam int SUM_AW    = 5;
    localparam int HIST_AW   = 5;

    typedef logic [1:0] op_t;
    localparam op_t OP_EMP = 2'd0;
    localparam op_t OP_SIM = 2'd1;
    localparam op_t OP_FIN = 2'd2;
    localparam op_t OP_RSV = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] sample;
    } in_word_t;

    typedef struct packed {
        logic [3:0]         moment_index;
        logic signed [63:0] difference;
        logic               last;
    } out_word_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] quotient;
    } div_resp_t;

    typedef enum logic [2:0] {
        K_SQ,
        K_LAG1,
        K_ABS,
        K_SQL,
        K_QUAD
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_READ,
        ST_PREP,
        ST_PP,
        ST_WRITE,
        ST_FREAD,
        ST_FSTART,
        ST_FDIV,
        ST_FEMIT
    } state_t;

    function automatic logic [4:0] mom_lag(input logic [3:0] k);
        case (k)
            4'd1, 4'd2, 4'd5:  mom_lag = 5'd1;
            4'd4, 4'd6:        mom_lag = 5'd5;
            4'd7, 4'd8:        mom_lag = 5'd10;
            4'd9, 4'd10:       mom_lag = 5'd15;
            4'd11, 4'd12:      mom_lag = 5'd20;
            4'd13, 4'd14:      mom_lag = 5'd25;
            default:           mom_lag = 5'd0;
        endcase
    endfunction

    function automatic kind_t mom_kind(input logic [3:0] k);
        case (k)
            4'd0:                                     mom_kind = K_SQ;
            4'd1:                                     mom_kind = K_LAG1;
            4'd3:                                     mom_kind = K_QUAD;
            4'd2, 4'd4, 4'd7, 4'd9, 4'd11, 4'd13:     mom_kind = K_SQL;
            default:                                  mom_kind = K_ABS;
        endcase
    endfunction

    // index of the final moment emitted for a given moment_count setting
    function automatic logic [3:0] emit_last(input logic [3:0] mc);
        if (mc < 4'd7) begin
            emit_last = 4'd3;
        end else if (mc < 4'd11) begin
            emit_last = 4'd6;
        end else if (mc < 4'd15) begin
            emit_last = 4'd10;
        end else begin
            emit_last = 4'd14;
        end
    endfunction

endpackage

// ----- sv/lmd_div.sv -----
// Bit-serial signed divider by an unsigned count, truncating toward zero.
module lmd_div #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lmd_pkg::div_req_t       req,
    input  logic [COUNT_WIDTH-1:0]  divisor,
    output lmd_pkg::div_resp_t      resp
);
    import lmd_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   neg_reg, neg_next;
    logic [5:0]             cnt_reg, cnt_next;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0] dvs_reg, dvs_next;
    logic [63:0]            quo_reg, quo_next;
    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH:0]   diff;
    logic                   ge;

    always_comb begin
        trial = {rem_reg, quo_reg[63]};
        ge    = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            neg_next  = req.dividend[63];
            quo_next  = req.dividend[63] ? 64'(-req.dividend) : 64'(req.dividend);
            rem_next  = '0;
            cnt_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[62:0], ge};
            rem_next = ge ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign resp.done     = done_reg;
    assign resp.quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// ----- sv/lagged_moment_difference.sv -----
// Top level: lagged moment accumulators for two return series and the difference emitter.
// Each sample word (op 0 empirical, op 1 simulated) updates fifteen saturating Q16.48 sums
// held in a 30-entry sum memory, through one shared 32x32 multiplier (sample square, then
// read, prep and write for each plain moment, with partial-product steps before the write
// for each moment that multiplies two squares). A finish word (op 2) reads back each sum
// pair, normalizes both through a bit-serial divider (skipped when the count does not
// exceed the lag) and emits 4, 7, 11 or 15 difference words, then clears the run; no
// clearing pass is needed. op 3 is taken and dropped. The result register lets the next
// sample word enter while the final difference still waits.
module lagged_moment_difference #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lmd_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lmd_pkg::out_word_t  m_data,
    input  logic                cfg_wr_en,
    input  logic [3:0]          cfg_wr_data
);
    import lmd_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    state_t state_reg, state_next;

    logic [3:0]              mc_reg;
    logic [3:0]              k_reg, k_next;
    logic                    side_reg, side_next;
    logic                    cur_series_reg, cur_series_next;
    logic [2:0]              pp_reg, pp_next;
    logic signed [31:0]      x_reg, x_next;
    logic [63:0]             sq_reg, sq_next;
    logic [63:0]             hq_reg, hq_next;
    logic [63:0]             mprod_reg, mprod_next;
    logic [127:0]            acc_reg, acc_next;
    logic signed [63:0]      e_reg, e_next;
    logic signed [63:0]      s_reg, s_next;
    logic [COUNT_WIDTH-1:0]  emp_cnt_reg, emp_cnt_next;
    logic [COUNT_WIDTH-1:0]  sim_cnt_reg, sim_cnt_next;
    logic [SUM_DEPTH-1:0]    vld_reg, vld_next;
    logic signed [31:0]      hist_reg [MAX_LAG];
    logic signed [31:0]      hist_next [MAX_LAG];
    logic                    m_valid_reg, m_valid_next;
    out_word_t               out_reg, out_next;

    logic [63:0]             sum_mem [SUM_DEPTH];
    logic [63:0]             rdata_reg;
    logic                    mem_re, mem_we;
    logic [SUM_AW-1:0]       mem_addr;
    logic [63:0]             mem_wd;

    div_req_t                div_req;
    div_resp_t               div_resp;
    logic [COUNT_WIDTH-1:0]  div_dvs;

    logic [4:0]              lag;
    kind_t                   kind;
    logic [HIST_AW-1:0]      hidx;
    logic signed [31:0]      h;
    logic [31:0]             mx, mh;
    logic [31:0]             mul_a, mul_b;
    logic [63:0]             mul_out;
    logic [63:0]             bsrc;
    logic [127:0]            acc_add;
    logic signed [63:0]      term;
    logic signed [63:0]      old_sum;
    logic [COUNT_WIDTH-1:0]  cnt_sel;
    logic                    short_series;
    logic [3:0]              klast;
    logic                    out_free;
    logic                    accept;

    function automatic logic signed [63:0] sat65(input logic signed [64:0] v);
        if (v[64] != v[63]) begin
            sat65 = v[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end else begin
            sat65 = v[63:0];
        end
    endfunction

    assign lag      = mom_lag(k_reg);
    assign kind     = mom_kind(k_reg);
    assign hidx     = (lag == 5'd0) ? '0 : HIST_AW'(lag - 5'd1);
    assign h        = hist_reg[hidx];
    assign mx       = x_reg[31] ? (~x_reg + 32'd1) : x_reg;
    assign mh       = h[31] ? (~h + 32'd1) : h;
    assign mul_out  = mul_a * mul_b;
    assign bsrc     = (kind == K_QUAD) ? sq_reg : hq_reg;
    assign mem_addr = side_reg ? (SUM_AW'(k_reg) + SUM_AW'(NMOM)) : SUM_AW'(k_reg);
    assign old_sum  = vld_reg[mem_addr] ? $signed(rdata_reg) : 64'sd0;
    assign cnt_sel  = side_reg ? sim_cnt_reg : emp_cnt_reg;
    assign short_series = cnt_sel <= COUNT_WIDTH'(lag);
    assign div_dvs  = cnt_sel - COUNT_WIDTH'(lag);
    assign klast    = emit_last(mc_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    // multiplier operand select
    always_comb begin
        mul_a = mx;
        mul_b = mh;
        case (state_reg)
            ST_SQUARE: begin
                mul_b = mx;
            end
            ST_READ: begin
                if (kind == K_SQL) begin
                    mul_a = mh;
                end
            end
            ST_PP: begin
                case (pp_reg)
                    3'd0: begin
                        mul_a = sq_reg[31:0];
                        mul_b = bsrc[31:0];
                    end
                    3'd1: begin
                        mul_a = sq_reg[31:0];
                        mul_b = bsrc[63:32];
                    end
                    3'd2: begin
                        mul_a = sq_reg[63:32];
                        mul_b = bsrc[31:0];
                    end
                    default: begin
                        mul_a = sq_reg[63:32];
                        mul_b = bsrc[63:32];
                    end
                endcase
            end
            default: begin
                mul_a = mx;
            end
        endcase
    end

    // partial product alignment: previous pp index sets the shift
    always_comb begin
        case (pp_reg)
            3'd1:    acc_add = {64'd0, mprod_reg};
            3'd2,
            3'd3:    acc_add = {32'd0, mprod_reg, 32'd0};
            default: acc_add = {mprod_reg, 64'd0};
        endcase
    end

    always_comb begin
        case (kind)
            K_SQ:    term = $signed(sq_reg);
            K_LAG1:  term = (x_reg[31] ^ h[31]) ? -$signed(mprod_reg) : $signed(mprod_reg);
            K_ABS:   term = $signed(mprod_reg);
            default: term = (|acc_reg[127:111]) ? 64'sh7FFF_FFFF_FFFF_FFFF
                                                : $signed(acc_reg[111:48]);
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.op == OP_EMP || s_data.op == OP_SIM) begin
                        state_next = ST_SQUARE;
                    end else if (s_data.op == OP_FIN) begin
                        state_next = ST_FREAD;
                    end
                end
            end
            ST_SQUARE: state_next = ST_READ;
            ST_READ:   state_next = ST_PREP;
            ST_PREP: begin
                state_next = (kind == K_SQL || kind == K_QUAD) ? ST_PP : ST_WRITE;
            end
            ST_PP: begin
                if (pp_reg == 3'd4) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                state_next = (k_reg == 4'(NMOM - 1)) ? ST_IDLE : ST_READ;
            end
            ST_FREAD: state_next = ST_FSTART;
            ST_FSTART: begin
                if (!short_series) begin
                    state_next = ST_FDIV;
                end else begin
                    state_next = side_reg ? ST_FEMIT : ST_FREAD;
                end
            end
            ST_FDIV: begin
                if (div_resp.done) begin
                    state_next = side_reg ? ST_FEMIT : ST_FREAD;
                end
            end
            ST_FEMIT: begin
                if (out_free) begin
                    state_next = (k_reg == klast) ? ST_IDLE : ST_FREAD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        k_next          = k_reg;
        side_next       = side_reg;
        cur_series_next = cur_series_reg;
        pp_next         = pp_reg;
        x_next          = x_reg;
        sq_next         = sq_reg;
        hq_next         = hq_reg;
        mprod_next      = mprod_reg;
        acc_next        = acc_reg;
        e_next          = e_reg;
        s_next          = s_reg;
        emp_cnt_next    = emp_cnt_reg;
        sim_cnt_next    = sim_cnt_reg;
        vld_next        = vld_reg;
        hist_next       = hist_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_wd          = 64'(sat65({old_sum[63], old_sum} + {term[63], term}));
        div_req.start   = 1'b0;
        div_req.dividend = old_sum;
        s_ready         = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    x_next = s_data.sample;
                    k_next = '0;
                    side_next = (s_data.op == OP_SIM);
                    if ((s_data.op == OP_EMP || s_data.op == OP_SIM)
                            && (s_data.op[0] != cur_series_reg)) begin
                        cur_series_next = s_data.op[0];
                        for (int i = 0; i < MAX_LAG; i++) begin
                            hist_next[i] = '0;
                        end
                    end
                end
            end
            ST_SQUARE: begin
                sq_next = mul_out;
            end
            ST_READ: begin
                mem_re     = 1'b1;
                mprod_next = mul_out;
            end
            ST_PREP: begin
                hq_next  = mprod_reg;
                pp_next  = '0;
                acc_next = '0;
            end
            ST_PP: begin
                mprod_next = mul_out;
                pp_next    = pp_reg + 3'd1;
                if (pp_reg != 3'd0) begin
                    acc_next = acc_reg + acc_add;
                end
            end
            ST_WRITE: begin
                mem_we = 1'b1;
                vld_next[mem_addr] = 1'b1;
                if (k_reg == 4'(NMOM - 1)) begin
                    hist_next[0] = x_reg;
                    for (int i = 1; i < MAX_LAG; i++) begin
                        hist_next[i] = hist_reg[i-1];
                    end
                    if (!side_reg) begin
                        if (emp_cnt_reg != CNT_MAX) emp_cnt_next = emp_cnt_reg + 1'b1;
                    end else begin
                        if (sim_cnt_reg != CNT_MAX) sim_cnt_next = sim_cnt_reg + 1'b1;
                    end
                end else begin
                    k_next = k_reg + 4'd1;
                end
            end
            ST_FREAD: begin
                mem_re = 1'b1;
            end
            ST_FSTART: begin
                if (short_series) begin
                    if (!side_reg) begin
                        e_next    = '0;
                        side_next = 1'b1;
                    end else begin
                        s_next = '0;
                    end
                end else begin
                    div_req.start = 1'b1;
                end
            end
            ST_FDIV: begin
                if (div_resp.done) begin
                    if (!side_reg) begin
                        e_next    = div_resp.quotient;
                        side_next = 1'b1;
                    end else begin
                        s_next = div_resp.quotient;
                    end
                end
            end
            ST_FEMIT: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    out_next.moment_index = k_reg;
                    out_next.difference   = sat65({e_reg[63], e_reg} - {s_reg[63], s_reg});
                    out_next.last         = (k_reg == klast);
                    side_next             = 1'b0;
                    if (k_reg == klast) begin
                        k_next       = '0;
                        vld_next     = '0;
                        emp_cnt_next = '0;
                        sim_cnt_next = '0;
                        for (int i = 0; i < MAX_LAG; i++) begin
                            hist_next[i] = '0;
                        end
                    end else begin
                        k_next = k_reg + 4'd1;
                    end
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mc_reg         <= 4'd15;
            k_reg          <= '0;
            side_reg       <= 1'b0;
            cur_series_reg <= 1'b0;
            pp_reg         <= '0;
            emp_cnt_reg    <= '0;
            sim_cnt_reg    <= '0;
            vld_reg        <= '0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < MAX_LAG; i++) begin
                hist_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            if (cfg_wr_en) mc_reg <= cfg_wr_data;
            k_reg          <= k_next;
            side_reg       <= side_next;
            cur_series_reg <= cur_series_next;
            pp_reg         <= pp_next;
            emp_cnt_reg    <= emp_cnt_next;
            sim_cnt_reg    <= sim_cnt_next;
            vld_reg        <= vld_next;
            m_valid_reg    <= m_valid_next;
            hist_reg       <= hist_next;
        end
        x_reg     <= x_next;
        sq_reg    <= sq_next;
        hq_reg    <= hq_next;
        mprod_reg <= mprod_next;
        acc_reg   <= acc_next;
        e_reg     <= e_next;
        s_reg     <= s_next;
        out_reg   <= out_next;
    end

    // sum memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) sum_mem[mem_addr] <= mem_wd;
        if (mem_re) rdata_reg <= sum_mem[mem_addr];
    end

    lmd_div #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .divisor (div_dvs),
        .resp    (div_resp)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ----- sv/lmd_checker.sv -----
// Port-level checks of the lagged moment difference block, bound to the top level.
module lmd_props (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input lmd_pkg::out_word_t  m_data
);
    import lmd_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result word changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a run still emitting takes no new word
    a_busy_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> !s_ready)
        else $error("input taken in the middle of a run");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.last) |-> (m_data.moment_index == 4'd3
            || m_data.moment_index == 4'd6 || m_data.moment_index == 4'd10
            || m_data.moment_index == 4'd14))
        else $error("last word on a wrong moment");

endmodule

bind lagged_moment_difference lmd_props u_lmd_props (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
